>>> src/snu_pkg.sv
// ----------------------------------------------------------------------------
// snu_pkg
// Shared types, constants and register codes of the spiking neuron
// update core: Q16.16 limits, model constants and the config register set.
// ----------------------------------------------------------------------------
package snu_pkg;

    // field widths
    localparam int Q_W       = 32;
    localparam int IDX_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int COUNT_W   = 11;
    localparam int RATE_W    = 16;
    localparam int BUMP_W    = 22;

    localparam int NEURON_COUNT_DEF = 1024;

    // q16.16 limits and model constants
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] C140    = 32'sh008C_0000;
    localparam logic signed [31:0] V_PEAK  = 32'sh001E_0000;
    localparam logic signed [31:0] V_RESET = 32'shFFBF_0000;
    localparam logic [11:0]        K_004   = 12'd2621;
    localparam logic signed [15:0] K_02    = 16'sd13107;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXC_COUNT = 3'd0,
        REG_RATE_EXC  = 3'd1,
        REG_RATE_INH  = 3'd2,
        REG_BUMP_EXC  = 3'd3,
        REG_BUMP_INH  = 3'd4
    } cfg_reg_e;

    // config register reset values
    localparam logic [COUNT_W-1:0] EXC_COUNT_RST = 11'd800;
    localparam logic [RATE_W-1:0]  RATE_EXC_RST  = 16'd1311;
    localparam logic [RATE_W-1:0]  RATE_INH_RST  = 16'd6554;
    localparam logic [BUMP_W-1:0]  BUMP_EXC_RST  = 22'd524288;
    localparam logic [BUMP_W-1:0]  BUMP_INH_RST  = 22'd131072;

    typedef struct packed {
        logic [COUNT_W-1:0] excitatory_count;
        logic [RATE_W-1:0]  rate_excitatory;
        logic [RATE_W-1:0]  rate_inhibitory;
        logic [BUMP_W-1:0]  bump_excitatory;
        logic [BUMP_W-1:0]  bump_inhibitory;
    } cfg_t;

endpackage

>>> src/snu_in_if.sv
// ----------------------------------------------------------------------------
// snu_in_if
// Input channel: load or step transaction for one neuron.
// ----------------------------------------------------------------------------
interface snu_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [snu_pkg::IDX_W-1:0]         neuron_index;
    logic signed [snu_pkg::Q_W-1:0]    input_current;
    logic signed [snu_pkg::Q_W-1:0]    load_potential;
    logic signed [snu_pkg::Q_W-1:0]    load_recovery;

    modport source (
        output valid, func, neuron_index, input_current, load_potential, load_recovery,
        input  ready
    );
    modport sink (
        input  valid, func, neuron_index, input_current, load_potential, load_recovery,
        output ready
    );
endinterface

>>> src/snu_out_if.sv
// ----------------------------------------------------------------------------
// snu_out_if
// Result channel: updated state of one neuron.
// ----------------------------------------------------------------------------
interface snu_out_if;
    logic                              valid;
    logic                              ready;
    logic [snu_pkg::IDX_W-1:0]         out_index;
    logic                              spiked;
    logic signed [snu_pkg::Q_W-1:0]    new_potential;
    logic signed [snu_pkg::Q_W-1:0]    new_recovery;
    logic                              saturated;

    modport source (
        output valid, out_index, spiked, new_potential, new_recovery, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_index, spiked, new_potential, new_recovery, saturated,
        output ready
    );
endinterface

>>> src/snu_cfg_if.sv
// ----------------------------------------------------------------------------
// snu_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface snu_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [snu_pkg::CFG_IDX_W-1:0]     index;
    logic [snu_pkg::CFG_DAT_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> src/snu_cfg_regs.sv
// ----------------------------------------------------------------------------
// snu_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module snu_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    snu_cfg_if.sink         cfg,
    output snu_pkg::cfg_t   cfg_q
);
    import snu_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.excitatory_count <= EXC_COUNT_RST;
            regs_reg.rate_excitatory  <= RATE_EXC_RST;
            regs_reg.rate_inhibitory  <= RATE_INH_RST;
            regs_reg.bump_excitatory  <= BUMP_EXC_RST;
            regs_reg.bump_inhibitory  <= BUMP_INH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_EXC_COUNT: regs_reg.excitatory_count <= cfg.data[COUNT_W-1:0];
                REG_RATE_EXC:  regs_reg.rate_excitatory  <= cfg.data[RATE_W-1:0];
                REG_RATE_INH:  regs_reg.rate_inhibitory  <= cfg.data[RATE_W-1:0];
                REG_BUMP_EXC:  regs_reg.bump_excitatory  <= cfg.data[BUMP_W-1:0];
                REG_BUMP_INH:  regs_reg.bump_inhibitory  <= cfg.data[BUMP_W-1:0];
                default:       ;
            endcase
        end
    end

endmodule

>>> src/spiking_neuron_update_core.sv
// an accepted transaction moves stage by stage until its result sits in the output register
// throughput: one transaction per cycle in the 12-stage pipeline while ready stays high
// a step on a neuron that still has an older transaction in stages 1 to 11 holds ready
// low until that one writes back, as does a stalled result side
// reset clears valid bits and config registers; the state memory is not cleared
// ----------------------------------------------------------------------------
// spiking_neuron_update_core
// Izhikevich neuron update engine: per-neuron potential and recovery in a
// memory, two half-millisecond potential updates, recovery update, spike
// detect and reset, all in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
module spiking_neuron_update_core #(
    parameter int NEURON_COUNT = snu_pkg::NEURON_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    snu_in_if.sink      item,
    snu_out_if.source   result,
    snu_cfg_if.sink     cfg
);
    import snu_pkg::*;

    localparam int ADDR_W = $clog2(NEURON_COUNT);

    // index to address wrap: reciprocal multiply, exact for 10-bit indexes
    localparam int RECIP = (2 ** 21 + NEURON_COUNT - 1) / NEURON_COUNT;
    localparam logic [20:0] RECIP_L = 21'(RECIP);
    localparam logic [16:0] COUNT_L = 17'(NEURON_COUNT);

    // pipeline stage numbers
    localparam logic [3:0] ST_FETCH  = 4'd1;   // memory read in flight
    localparam logic [3:0] ST_SQ_A   = 4'd2;   // operand select, v squared
    localparam logic [3:0] ST_QUAD_A = 4'd3;   // times 0.04
    localparam logic [3:0] ST_HALF_A = 4'd4;   // first half step, saturate
    localparam logic [3:0] ST_SQ_B   = 4'd5;
    localparam logic [3:0] ST_QUAD_B = 4'd6;
    localparam logic [3:0] ST_HALF_B = 4'd7;   // second half step
    localparam logic [3:0] ST_SCALE  = 4'd8;   // 0.2 * v
    localparam logic [3:0] ST_DIFF   = 4'd9;   // minus u
    localparam logic [3:0] ST_RATE   = 4'd10;  // times a
    localparam logic [3:0] ST_REC    = 4'd11;  // recovery update, spike detect
    localparam logic [3:0] ST_SPIKE  = 4'd12;  // spike reset, output register
    localparam int         LAST      = 12;

    typedef struct packed {
        logic                  func;
        logic [IDX_W-1:0]      idx;
        logic [ADDR_W-1:0]     addr;
        logic signed [31:0]    cur;
        logic signed [31:0]    v;
        logic signed [31:0]    u;
        logic [RATE_W-1:0]     a;
        logic [BUMP_W-1:0]     d;
        logic                  sat;
        logic                  spk;
        logic [63:0]           acc;   // product of the stage before
        logic signed [36:0]    rest;  // linear part of the sum, later the recovery difference
    } item_t;

    cfg_t cfg_q;

    snu_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // state memory: potential in the upper half, recovery in the lower
    logic [63:0]        state_mem [NEURON_COUNT];
    logic [63:0]        rd_reg;

    item_t              st_reg  [1:LAST];
    item_t              st_next [1:LAST];
    logic [LAST:1]      valid_reg;
    logic [LAST:1]      valid_next;
    logic [LAST:1]      adv;

    logic [30:0]        idx_prod;
    logic [26:0]        idx_rem;
    logic [ADDR_W-1:0]  in_addr;
    logic               hazard;
    logic               accept;
    logic               exc;
    logic               stage_conflict;

    // saturation helpers
    function automatic logic ovf32(input logic signed [47:0] x);
        return x[47:31] != {17{x[31]}};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        if (ovf32(x))
            return x[47] ? Q_MIN : Q_MAX;
        return x[31:0];
    endfunction

    // work done on the way into stage k
    function automatic item_t stage_fn(input logic [3:0] k, input item_t s_in,
                                       input logic [63:0] rd);
        item_t              s;
        logic [31:0]        mag;
        logic signed [36:0] v37;
        logic signed [36:0] u37;
        logic signed [36:0] c37;
        logic signed [45:0] sum_h;
        logic signed [46:0] p47;
        logic signed [50:0] p51;
        logic signed [47:0] x48;
        s = s_in;
        case (k)
            ST_SQ_A, ST_SQ_B:
            begin
                if (k == ST_SQ_A && s.func)
                begin
                    s.v = $signed(rd[63:32]);
                    s.u = $signed(rd[31:0]);
                end
                mag    = s.v[31] ? 32'(-s.v) : 32'(s.v);
                s.acc  = 64'(mag) * 64'(mag);
                v37    = 37'(s.v);
                u37    = 37'(s.u);
                c37    = 37'(s.cur);
                s.rest = (v37 <<< 2) + v37 - u37 + c37 + 37'(C140);
            end
            ST_QUAD_A, ST_QUAD_B:
            begin
                s.acc = 64'(60'(s.acc[63:16]) * 60'(K_004));
            end
            ST_HALF_A, ST_HALF_B:
            begin
                sum_h = $signed({2'b00, s.acc[59:16]}) + 46'(s.rest);
                x48   = 48'(s.v) + 48'(sum_h >>> 1);
                if (s.func)
                begin
                    s.v   = sat32(x48);
                    s.sat = s.sat | ovf32(x48);
                end
            end
            ST_SCALE:
            begin
                p47   = 47'(s.v) * 47'(K_02);
                s.acc = 64'(p47);
            end
            ST_DIFF:
            begin
                s.rest = 37'($signed(s.acc[46:16])) - 37'(s.u);
            end
            ST_RATE:
            begin
                p51   = 51'($signed({1'b0, s.a})) * 51'(s.rest);
                s.acc = 64'(p51);
            end
            ST_REC:
            begin
                x48 = 48'(s.u) + 48'($signed(s.acc[50:16]));
                if (s.func)
                begin
                    s.u   = sat32(x48);
                    s.sat = s.sat | ovf32(x48);
                end
                s.spk = s.func && (s.v >= V_PEAK);
            end
            ST_SPIKE:
            begin
                if (s.spk)
                begin
                    x48   = 48'(s.u) + 48'($signed({1'b0, s.d}));
                    s.v   = V_RESET;
                    s.u   = sat32(x48);
                    s.sat = s.sat | ovf32(x48);
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    // address wrap of the incoming index
    assign idx_prod = 31'(item.neuron_index) * 31'(RECIP_L);
    assign idx_rem  = 27'(item.neuron_index) - 27'(idx_prod[30:21]) * 27'(COUNT_L);
    assign in_addr  = idx_rem[ADDR_W-1:0];

    // a step must not read a neuron that an older transaction has yet to write back
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 1; k < LAST; k++)
        begin
            if (valid_reg[k] && st_reg[k].addr == in_addr)
                hazard = 1'b1;
        end
        hazard = hazard & item.func;
    end

    // per-stage advance: a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || result.ready;
        for (int k = LAST - 1; k >= 1; k--)
            adv[k] = !valid_reg[k] || adv[k + 1];
    end

    assign item.ready = adv[ST_FETCH] && !hazard;
    assign accept     = item.valid && item.ready;
    assign exc        = {1'b0, item.neuron_index} < cfg_q.excitatory_count;

    always_comb
    begin
        st_next[1].func = item.func;
        st_next[1].idx  = item.neuron_index;
        st_next[1].addr = in_addr;
        st_next[1].cur  = item.input_current;
        st_next[1].v    = item.load_potential;
        st_next[1].u    = item.load_recovery;
        st_next[1].a    = exc ? cfg_q.rate_excitatory : cfg_q.rate_inhibitory;
        st_next[1].d    = exc ? cfg_q.bump_excitatory : cfg_q.bump_inhibitory;
        st_next[1].sat  = 1'b0;
        st_next[1].spk  = 1'b0;
        st_next[1].acc  = '0;
        st_next[1].rest = '0;
        for (int k = 2; k <= LAST; k++)
            st_next[k] = stage_fn(4'(k), st_reg[k - 1], rd_reg);
    end

    always_comb
    begin
        valid_next[1] = adv[1] ? accept : valid_reg[1];
        for (int k = 2; k <= LAST; k++)
            valid_next[k] = adv[k] ? valid_reg[k - 1] : valid_reg[k];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // payload, memory read and write-back
    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= LAST; k++)
        begin
            if (adv[k])
                st_reg[k] <= st_next[k];
        end
        if (adv[ST_FETCH])
            rd_reg <= state_mem[in_addr];
        // the transaction entering the output register writes its neuron back
        if (adv[LAST] && valid_reg[LAST - 1])
            state_mem[st_next[LAST].addr] <= {st_next[LAST].v, st_next[LAST].u};
    end

    // result channel straight from the last stage
    assign result.valid         = valid_reg[LAST];
    assign result.out_index     = st_reg[LAST].idx;
    assign result.spiked        = st_reg[LAST].spk;
    assign result.new_potential = st_reg[LAST].v;
    assign result.new_recovery  = st_reg[LAST].u;
    assign result.saturated     = st_reg[LAST].sat;

    // a step in the fetch stage never shares its neuron with an older one in flight
    always_comb
    begin
        stage_conflict = 1'b0;
        for (int k = 2; k < LAST; k++)
        begin
            if (valid_reg[ST_FETCH] && st_reg[ST_FETCH].func && valid_reg[k]
                && st_reg[k].addr == st_reg[ST_FETCH].addr)
                stage_conflict = 1'b1;
        end
    end

    a_no_raw_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_conflict)
        else $error("two in-flight transactions on one neuron");

    a_spike_resets: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && st_reg[LAST].spk |-> st_reg[LAST].v == V_RESET)
        else $error("spike without potential reset");

    a_spike_is_step: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && st_reg[LAST].spk |-> st_reg[LAST].func)
        else $error("spike flagged on a load");

    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && !st_reg[LAST].func |-> !st_reg[LAST].sat)
        else $error("saturation flagged on a load");

endmodule
